// ----- rtl/asfe_pkg.sv -----
// ----------------------------------------------------------------------------
// asfe_pkg
// Shared constants, command codes and status bundle of the adaptive
// Shannon-Fano encoder.
// ----------------------------------------------------------------------------
package asfe_pkg;

	localparam int unsigned TABLE_DEPTH_DEFAULT = 64;
	localparam int unsigned SYM_W               = 32;
	localparam int unsigned CNT_W               = 32;
	localparam int unsigned BC_W                = 6;
	localparam int unsigned CHUNK_W             = 32;
	localparam logic [SYM_W-1:0] ESCAPE_VALUE   = 32'h7fff_ffff;
	localparam logic [BC_W-1:0]  CHUNK_BITS     = 6'd32;

	// datapath commands issued by the controller
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_INIT,
		CMD_LOAD,
		CMD_SRCH_RD,
		CMD_SRCH_CMP,
		CMD_RESOLVE,
		CMD_SUM_START,
		CMD_SUM_RD,
		CMD_SUM_ADD,
		CMD_WALK_START,
		CMD_WALK_INIT,
		CMD_WALK_RD,
		CMD_WALK_ADD,
		CMD_SPLIT,
		CMD_EMIT_CODE,
		CMD_EMIT_RAW,
		CMD_APPEND,
		CMD_BUMP_RD,
		CMD_BUMP_GET,
		CMD_SCAN_RD,
		CMD_SCAN_CMP,
		CMD_WR_SELF,
		CMD_T_RD,
		CMD_WR_POS,
		CMD_WR_T
	} cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic srch_last;
		logic unknown;
		logic split_done;
		logic code_full;
		logic has_code;
		logic out_free;
		logic append_req;
		logic sum_last;
		logic walk_go;
		logic pos_zero;
		logic scan_hit;
		logic scan_end;
		logic t_is_pos;
	} status_t;

endpackage

// ----- rtl/asfe_ram.sv -----
// ----------------------------------------------------------------------------
// asfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asfe_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/asfe_datapath.sv -----
// ----------------------------------------------------------------------------
// asfe_datapath
// Symbol table storage, search, split arithmetic, code packing, output
// register and table reorder, all stepped by controller commands.
// ----------------------------------------------------------------------------
module asfe_datapath #(
	parameter int unsigned TABLE_DEPTH = asfe_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  asfe_pkg::cmd_t     cmd,
	output asfe_pkg::status_t  status,
	input  logic [31:0]        s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	localparam int unsigned AW   = $clog2(TABLE_DEPTH);
	localparam int unsigned UW   = AW + 1;
	localparam int unsigned SUMW = asfe_pkg::CNT_W + AW;

	localparam logic [UW-1:0]                  DEPTH_U  = UW'(TABLE_DEPTH);
	localparam logic [asfe_pkg::CNT_W-1:0]     CNT_MAX  = '1;
	localparam logic [asfe_pkg::CNT_W-1:0]     CNT_ONE  = asfe_pkg::CNT_W'(1);

	// table storage
	logic                       val_we, cnt_we;
	logic [AW-1:0]              val_waddr, cnt_waddr, val_raddr, cnt_raddr;
	logic [asfe_pkg::SYM_W-1:0] val_wdata, val_rdata;
	logic [asfe_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata;

	// working registers
	logic [asfe_pkg::SYM_W-1:0] sym_q, v_q;
	logic [asfe_pkg::CNT_W-1:0] c_q, tcnt_q;
	logic [UW-1:0]              used_q;
	logic [AW-1:0]              idx_q, pos_q, esc_q, lo_q, hi_q, t_q;
	logic                       found_q, unknown_q, full_q, stepped_q;
	logic [SUMW-1:0]            tot_q, up_q, gap_q;
	logic [asfe_pkg::CHUNK_W-1:0] code_q;
	logic [asfe_pkg::BC_W-1:0]  ncode_q;

	// output register
	logic                         m_tvalid_q;
	logic [asfe_pkg::CHUNK_W-1:0] out_code_q;
	logic [asfe_pkg::BC_W-1:0]    out_cnt_q;
	logic                         out_last_q, out_full_q;

	logic [SUMW-1:0] lower, up_ext, cur_diff;
	logic            dec;
	logic [AW-1:0]   k_raw, k;
	logic            code_bit;
	logic [UW-1:0]   used_m1;
	logic [asfe_pkg::CNT_W-1:0] c_next;

	asfe_ram #(.WIDTH(asfe_pkg::SYM_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	asfe_ram #(.WIDTH(asfe_pkg::CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// split arithmetic
	assign used_m1  = used_q - UW'(1);
	assign lower    = tot_q - up_q;
	assign up_ext   = SUMW'(cnt_rdata);
	assign cur_diff = up_q - lower;
	assign dec      = stepped_q && (gap_q < cur_diff);
	assign k_raw    = dec ? (idx_q - AW'(1)) : idx_q;
	assign k        = (k_raw >= hi_q) ? (hi_q - AW'(1)) : k_raw;
	assign code_bit = (pos_q > k);
	assign c_next   = (cnt_rdata == CNT_MAX) ? cnt_rdata : (cnt_rdata + CNT_ONE);

	// read addresses
	always_comb begin
		val_raddr = idx_q;
		cnt_raddr = idx_q;
		unique case (cmd)
			asfe_pkg::CMD_WALK_START: cnt_raddr = lo_q;
			asfe_pkg::CMD_WALK_RD:    cnt_raddr = idx_q + AW'(1);
			asfe_pkg::CMD_BUMP_RD: begin
				val_raddr = pos_q;
				cnt_raddr = pos_q;
			end
			asfe_pkg::CMD_SCAN_RD:    cnt_raddr = idx_q - AW'(1);
			asfe_pkg::CMD_T_RD:       val_raddr = t_q;
			default: ;
		endcase
	end

	// write ports
	always_comb begin
		val_we    = 1'b0;
		cnt_we    = 1'b0;
		val_waddr = pos_q;
		cnt_waddr = pos_q;
		val_wdata = v_q;
		cnt_wdata = c_q;
		unique case (cmd)
			asfe_pkg::CMD_INIT: begin
				val_we    = 1'b1;
				cnt_we    = 1'b1;
				val_waddr = '0;
				cnt_waddr = '0;
				val_wdata = asfe_pkg::ESCAPE_VALUE;
				cnt_wdata = CNT_ONE;
			end
			asfe_pkg::CMD_APPEND: begin
				val_we    = 1'b1;
				cnt_we    = 1'b1;
				val_waddr = used_q[AW-1:0];
				cnt_waddr = used_q[AW-1:0];
				val_wdata = sym_q;
				cnt_wdata = CNT_ONE;
			end
			asfe_pkg::CMD_WR_SELF: begin
				cnt_we = 1'b1;
			end
			asfe_pkg::CMD_WR_POS: begin
				val_we    = 1'b1;
				cnt_we    = 1'b1;
				val_wdata = val_rdata;
				cnt_wdata = tcnt_q;
			end
			asfe_pkg::CMD_WR_T: begin
				val_we    = 1'b1;
				cnt_we    = 1'b1;
				val_waddr = t_q;
				cnt_waddr = t_q;
			end
			default: ;
		endcase
	end

	// table fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= UW'(1);
		end else if (cmd == asfe_pkg::CMD_INIT) begin
			used_q <= UW'(1);
		end else if (cmd == asfe_pkg::CMD_APPEND) begin
			used_q <= used_q + UW'(1);
		end
	end

	// working registers, advanced by command
	always_ff @(posedge clk) begin
		unique case (cmd)
			asfe_pkg::CMD_LOAD: begin
				sym_q   <= s_tdata;
				idx_q   <= '0;
				found_q <= 1'b0;
				esc_q   <= '0;
				pos_q   <= '0;
				code_q  <= '0;
				ncode_q <= '0;
			end
			asfe_pkg::CMD_SRCH_CMP: begin
				if (val_rdata == asfe_pkg::ESCAPE_VALUE) begin
					esc_q <= idx_q;
				end
				if (!found_q && val_rdata == sym_q) begin
					pos_q   <= idx_q;
					found_q <= 1'b1;
				end
				idx_q <= idx_q + AW'(1);
			end
			asfe_pkg::CMD_RESOLVE: begin
				unknown_q <= !found_q || sym_q == asfe_pkg::ESCAPE_VALUE;
				full_q    <= (!found_q && sym_q != asfe_pkg::ESCAPE_VALUE && used_q >= DEPTH_U);
				if (!found_q || sym_q == asfe_pkg::ESCAPE_VALUE) begin
					pos_q <= esc_q;
				end
				lo_q <= '0;
				hi_q <= used_m1[AW-1:0];
			end
			asfe_pkg::CMD_SUM_START: begin
				idx_q <= lo_q;
				tot_q <= '0;
			end
			asfe_pkg::CMD_SUM_ADD: begin
				tot_q <= tot_q + up_ext;
				idx_q <= idx_q + AW'(1);
			end
			asfe_pkg::CMD_WALK_START: begin
				idx_q     <= lo_q;
				stepped_q <= 1'b0;
			end
			asfe_pkg::CMD_WALK_INIT: begin
				up_q <= up_ext;
			end
			asfe_pkg::CMD_WALK_RD: begin
				gap_q     <= lower - up_q;
				stepped_q <= 1'b1;
				idx_q     <= idx_q + AW'(1);
			end
			asfe_pkg::CMD_WALK_ADD: begin
				up_q <= up_q + up_ext;
			end
			asfe_pkg::CMD_SPLIT: begin
				code_q  <= {code_q[asfe_pkg::CHUNK_W-2:0], code_bit};
				ncode_q <= ncode_q + asfe_pkg::BC_W'(1);
				if (code_bit) begin
					lo_q <= k + AW'(1);
				end else begin
					hi_q <= k;
				end
			end
			asfe_pkg::CMD_EMIT_CODE: begin
				code_q  <= '0;
				ncode_q <= '0;
			end
			asfe_pkg::CMD_BUMP_GET: begin
				v_q   <= val_rdata;
				c_q   <= c_next;
				t_q   <= pos_q;
				idx_q <= pos_q;
			end
			asfe_pkg::CMD_SCAN_RD: begin
				idx_q <= idx_q - AW'(1);
			end
			asfe_pkg::CMD_SCAN_CMP: begin
				if (cnt_rdata < c_q) begin
					t_q    <= idx_q;
					tcnt_q <= cnt_rdata;
				end
			end
			default: ;
		endcase
	end

	// output register: load on emit, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd == asfe_pkg::CMD_EMIT_CODE || cmd == asfe_pkg::CMD_EMIT_RAW) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == asfe_pkg::CMD_EMIT_CODE) begin
			out_code_q <= code_q;
			out_cnt_q  <= ncode_q;
			out_last_q <= (lo_q == hi_q) && !unknown_q;
			out_full_q <= full_q;
		end else if (cmd == asfe_pkg::CMD_EMIT_RAW) begin
			out_code_q <= sym_q;
			out_cnt_q  <= asfe_pkg::CHUNK_BITS;
			out_last_q <= 1'b1;
			out_full_q <= full_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_code_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_full_q;

	// status back to the controller
	always_comb begin
		status.srch_last  = ({1'b0, idx_q} == used_m1);
		status.unknown    = unknown_q;
		status.split_done = (lo_q == hi_q);
		status.code_full  = (ncode_q == asfe_pkg::CHUNK_BITS);
		status.has_code   = (ncode_q != '0);
		status.out_free   = !m_tvalid_q || m_tready;
		status.append_req = unknown_q && !full_q && sym_q != asfe_pkg::ESCAPE_VALUE;
		status.sum_last   = (idx_q == hi_q);
		status.walk_go    = (up_q < lower) && (idx_q != hi_q);
		status.pos_zero   = (pos_q == '0);
		status.scan_hit   = (cnt_rdata < c_q);
		status.scan_end   = (idx_q == '0);
		status.t_is_pos   = (t_q == pos_q);
	end

	// the table never grows past its depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != '0) && (used_q <= DEPTH_U))
		else $error("entry count out of range");

	// a split only runs on a range of two or more entries
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == asfe_pkg::CMD_SPLIT) |-> (lo_q < hi_q))
		else $error("split on a single-entry range");

	// an emitted code chunk is never empty
	a_chunk_size: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == asfe_pkg::CMD_EMIT_CODE) |=> (out_cnt_q != '0))
		else $error("empty code chunk");

endmodule

// ----- rtl/asfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// asfe_ctrl
// Sequencer of the encoder: search, split loop, chunk emission and table
// reorder, one symbol at a time.
// ----------------------------------------------------------------------------
module asfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  asfe_pkg::status_t status,
	output asfe_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_RESOLVE, ST_CHECK,
		ST_SUM_START, ST_SUM_RD, ST_SUM_ADD, ST_WALK_START, ST_WALK_INIT,
		ST_WALK_TEST, ST_WALK_RD, ST_WALK_ADD, ST_SPLIT, ST_EMIT_CODE,
		ST_EMIT_RAW, ST_APPEND, ST_BUMP_RD, ST_BUMP_GET, ST_SCAN_RD,
		ST_SCAN_CMP, ST_SWAP_SEL, ST_WR_SELF, ST_T_RD, ST_WR_POS, ST_WR_T
	} state_t;

	state_t state_q;
	logic   s_tready_q;

	// command decode
	always_comb begin
		unique case (state_q)
			ST_INIT:       cmd = asfe_pkg::CMD_INIT;
			ST_IDLE:       cmd = s_tvalid ? asfe_pkg::CMD_LOAD : asfe_pkg::CMD_NONE;
			ST_SRCH_RD:    cmd = asfe_pkg::CMD_SRCH_RD;
			ST_SRCH_CMP:   cmd = asfe_pkg::CMD_SRCH_CMP;
			ST_RESOLVE:    cmd = asfe_pkg::CMD_RESOLVE;
			ST_SUM_START:  cmd = asfe_pkg::CMD_SUM_START;
			ST_SUM_RD:     cmd = asfe_pkg::CMD_SUM_RD;
			ST_SUM_ADD:    cmd = asfe_pkg::CMD_SUM_ADD;
			ST_WALK_START: cmd = asfe_pkg::CMD_WALK_START;
			ST_WALK_INIT:  cmd = asfe_pkg::CMD_WALK_INIT;
			ST_WALK_RD:    cmd = asfe_pkg::CMD_WALK_RD;
			ST_WALK_ADD:   cmd = asfe_pkg::CMD_WALK_ADD;
			ST_SPLIT:      cmd = asfe_pkg::CMD_SPLIT;
			ST_EMIT_CODE:  cmd = status.out_free ? asfe_pkg::CMD_EMIT_CODE
			                                     : asfe_pkg::CMD_NONE;
			ST_EMIT_RAW:   cmd = status.out_free ? asfe_pkg::CMD_EMIT_RAW
			                                     : asfe_pkg::CMD_NONE;
			ST_APPEND:     cmd = asfe_pkg::CMD_APPEND;
			ST_BUMP_RD:    cmd = asfe_pkg::CMD_BUMP_RD;
			ST_BUMP_GET:   cmd = asfe_pkg::CMD_BUMP_GET;
			ST_SCAN_RD:    cmd = asfe_pkg::CMD_SCAN_RD;
			ST_SCAN_CMP:   cmd = asfe_pkg::CMD_SCAN_CMP;
			ST_WR_SELF:    cmd = asfe_pkg::CMD_WR_SELF;
			ST_T_RD:       cmd = asfe_pkg::CMD_T_RD;
			ST_WR_POS:     cmd = asfe_pkg::CMD_WR_POS;
			ST_WR_T:       cmd = asfe_pkg::CMD_WR_T;
			default:       cmd = asfe_pkg::CMD_NONE;
		endcase
	end

	// state and input ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			s_tready_q <= 1'b0;
		end else begin
			s_tready_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					state_q    <= ST_IDLE;
					s_tready_q <= 1'b1;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SRCH_RD;
					end else begin
						s_tready_q <= 1'b1;
					end
				end
				ST_SRCH_RD:  state_q <= ST_SRCH_CMP;
				ST_SRCH_CMP: state_q <= status.srch_last ? ST_RESOLVE : ST_SRCH_RD;
				ST_RESOLVE:  state_q <= ST_CHECK;
				ST_CHECK: begin
					priority if (status.split_done) begin
						if (status.has_code) state_q <= ST_EMIT_CODE;
						else if (status.unknown) state_q <= ST_EMIT_RAW;
						else state_q <= ST_BUMP_RD;
					end else if (status.code_full) begin
						state_q <= ST_EMIT_CODE;
					end else begin
						state_q <= ST_SUM_START;
					end
				end
				ST_SUM_START:  state_q <= ST_SUM_RD;
				ST_SUM_RD:     state_q <= ST_SUM_ADD;
				ST_SUM_ADD:    state_q <= status.sum_last ? ST_WALK_START : ST_SUM_RD;
				ST_WALK_START: state_q <= ST_WALK_INIT;
				ST_WALK_INIT:  state_q <= ST_WALK_TEST;
				ST_WALK_TEST:  state_q <= status.walk_go ? ST_WALK_RD : ST_SPLIT;
				ST_WALK_RD:    state_q <= ST_WALK_ADD;
				ST_WALK_ADD:   state_q <= ST_WALK_TEST;
				ST_SPLIT:      state_q <= ST_CHECK;
				ST_EMIT_CODE: begin
					if (status.out_free) begin
						priority if (!status.split_done) state_q <= ST_SUM_START;
						else if (status.unknown) state_q <= ST_EMIT_RAW;
						else state_q <= ST_BUMP_RD;
					end
				end
				ST_EMIT_RAW: begin
					if (status.out_free) begin
						state_q <= status.append_req ? ST_APPEND : ST_BUMP_RD;
					end
				end
				ST_APPEND:   state_q <= ST_BUMP_RD;
				ST_BUMP_RD:  state_q <= ST_BUMP_GET;
				ST_BUMP_GET: state_q <= status.pos_zero ? ST_WR_SELF : ST_SCAN_RD;
				ST_SCAN_RD:  state_q <= ST_SCAN_CMP;
				ST_SCAN_CMP: begin
					state_q <= (status.scan_hit && !status.scan_end) ? ST_SCAN_RD
					                                                 : ST_SWAP_SEL;
				end
				ST_SWAP_SEL: state_q <= status.t_is_pos ? ST_WR_SELF : ST_T_RD;
				ST_T_RD:     state_q <= ST_WR_POS;
				ST_WR_POS:   state_q <= ST_WR_T;
				ST_WR_SELF, ST_WR_T: begin
					state_q    <= ST_IDLE;
					s_tready_q <= 1'b1;
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = s_tready_q;

	// results leave only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == asfe_pkg::CMD_EMIT_CODE || cmd == asfe_pkg::CMD_EMIT_RAW)
		|-> status.out_free)
		else $error("emit into a busy output register");

	// a new symbol is taken only from the idle state
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (state_q == ST_IDLE && cmd == asfe_pkg::CMD_LOAD))
		else $error("symbol accepted outside idle");

	// the table is reordered only after the last result is handed over
	a_bump_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUMP_RD) |-> (status.split_done))
		else $error("reorder before the code is complete");

endmodule

// ----- rtl/adaptive_shannon_fano_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// adaptive_shannon_fano_encoder_unit
// Adaptive Shannon-Fano encoder: one 32-bit symbol in, one to several code
// chunks out, with an adaptive count-sorted symbol table.
// ----------------------------------------------------------------------------
// The block takes one symbol at a time and returns its code as chunks of up
// to 32 bits (right aligned, first bit at position bit_count-1); an unknown
// symbol is sent as the escape code followed by its raw 32 bits, and tlast
// marks the final chunk. A symbol goes through the table search over the N
// entries in use, then, for each code bit, a sum of the counts of the current
// range, a split walk and the split itself, then the chunk hand-off, the
// append of a new symbol, the reorder scan and the write-back; the table RAMs
// have registered reads, and a stalled output adds its stall to each chunk.
// A new symbol is accepted only once the previous one is fully processed.
// After reset the block writes the escape entry before it raises s_tready.
module adaptive_shannon_fano_encoder_unit #(
	parameter int unsigned TABLE_DEPTH = asfe_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] symbol
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] code_bits, [37:32] bit_count
	output logic        m_tlast,
	output logic        m_tuser    // [0] table_full
);

	asfe_pkg::cmd_t    cmd;
	asfe_pkg::status_t status;

	asfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	asfe_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- test/tb_adaptive_shannon_fano_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_adaptive_shannon_fano_encoder_unit
// Self-checking bench for the adaptive Shannon-Fano encoder: streams symbols
// (directed table, then random), predicts the code chunks with a local copy of
// the count-sorted table and compares every output transaction in order.
// ----------------------------------------------------------------------------
module tb_adaptive_shannon_fano_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = asfe_pkg::TABLE_DEPTH_DEFAULT;
	localparam int N_RANDOM = 180;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct packed {
		logic [31:0] code_bits;
		logic [5:0]  bit_count;
		logic        last;
		logic        table_full;
	} chunk_t;

	typedef struct {
		logic [31:0] symbol;
		logic        typed;
		chunk_t      chunk;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	adaptive_shannon_fano_encoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// predictor state: the symbol table sorted by count
	logic [31:0] sym_tab [DEPTH];
	logic [31:0] cnt_tab [DEPTH];
	int          n_used;
	bit          code_path [DEPTH];
	chunk_t      pending_chunks [$];
	int          n_errors = 0;
	longint      n_cycles = 0;

	function automatic int find_split(int lo, int hi);
		longint upper, lower, prev_diff;
		int i;
		upper = cnt_tab[lo];
		lower = 0;
		for (i = lo + 1; i <= hi; i++) lower += cnt_tab[i];
		prev_diff = upper - lower;
		i = lo;
		while (upper < lower && i < hi) begin
			prev_diff = upper - lower;
			i++;
			upper += cnt_tab[i];
			lower -= cnt_tab[i];
		end
		if (prev_diff < 0 && -prev_diff < upper - lower) i--;
		if (i >= hi) i = hi - 1;
		return i;
	endfunction

	function automatic int build_code(int pos);
		int lo, hi, n, k;
		lo = 0;
		hi = n_used - 1;
		n = 0;
		while (lo != hi && n < DEPTH) begin
			k = find_split(lo, hi);
			if (pos <= k) begin
				code_path[n] = 0;
				hi = k;
			end else begin
				code_path[n] = 1;
				lo = k + 1;
			end
			n++;
		end
		return n;
	endfunction

	// raise the count (saturating) and move the entry ahead of lower counts
	function automatic void promote(int pos);
		logic [31:0] v, c;
		int i;
		if (cnt_tab[pos] != 32'hffff_ffff) cnt_tab[pos]++;
		if (pos == 0) return;
		v = sym_tab[pos];
		c = cnt_tab[pos];
		i = pos - 1;
		while (i >= 0 && cnt_tab[i] < c) i--;
		sym_tab[pos] = sym_tab[i + 1];
		cnt_tab[pos] = cnt_tab[i + 1];
		sym_tab[i + 1] = v;
		cnt_tab[i + 1] = c;
	endfunction

	function automatic void predict_chunks(logic [31:0] sym);
		int pos, esc, nbits, done, take, b;
		bit found, unknown, full;
		chunk_t ch;
		pos = 0; esc = 0; found = 0; full = 0; done = 0;
		for (int i = 0; i < n_used; i++) begin
			if (sym_tab[i] == asfe_pkg::ESCAPE_VALUE) esc = i;
			if (!found && sym_tab[i] == sym) begin
				pos = i;
				found = 1;
			end
		end
		unknown = !found || sym == asfe_pkg::ESCAPE_VALUE;
		if (unknown) pos = esc;
		full = unknown && sym != asfe_pkg::ESCAPE_VALUE && n_used >= DEPTH;
		nbits = build_code(pos);
		while (done < nbits) begin
			take = (nbits - done > 32) ? 32 : nbits - done;
			ch = '0;
			for (b = 0; b < take; b++)
				ch.code_bits = {ch.code_bits[30:0], code_path[done + b]};
			done += take;
			ch.bit_count = 6'(take);
			ch.last = !unknown && done == nbits;
			ch.table_full = full;
			pending_chunks.push_back(ch);
		end
		if (unknown) begin
			ch.code_bits = sym;
			ch.bit_count = 6'd32;
			ch.last = 1'b1;
			ch.table_full = full;
			pending_chunks.push_back(ch);
			if (sym != asfe_pkg::ESCAPE_VALUE && !full) begin
				sym_tab[n_used] = sym;
				cnt_tab[n_used] = 0;
				n_used++;
				promote(n_used - 1);
			end
		end
		promote(pos);
	endfunction

	// send one symbol, after a random idle gap when gaps is set; hold it until accepted, predict then
	task automatic send_symbol(logic [31:0] sym, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sym;
		do @(posedge clk); while (!s_tready);
		predict_chunks(sym);
	endtask

	task automatic wait_drained();
		while (pending_chunks.size() != 0) @(posedge clk);
	endtask

	// cycle limit
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output side: random stalls and in-order compare
	bit gaps_on = 1;
	int stall_left = 0;
	always @(posedge clk) begin
		chunk_t got, exp_c;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[37:32], m_tlast, m_tuser};
			if (pending_chunks.size() == 0) begin
				$display("%0t unexpected chunk %h", $time, got);
				n_errors++;
			end else begin
				exp_c = pending_chunks.pop_front();
				if (got.code_bits !== exp_c.code_bits)
					$display("%0t code_bits exp %h got %h", $time, exp_c.code_bits,
						got.code_bits);
				if (got.bit_count !== exp_c.bit_count)
					$display("%0t bit_count exp %0d got %0d", $time, exp_c.bit_count,
						got.bit_count);
				if (got.last !== exp_c.last)
					$display("%0t last exp %b got %b", $time, exp_c.last, got.last);
				if (got.table_full !== exp_c.table_full)
					$display("%0t table_full exp %b got %b", $time, exp_c.table_full,
						got.table_full);
				if (got !== exp_c) n_errors++;
			end
			stall_left = gaps_on ? $urandom_range(0, 11) : 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	row_t dir_rows [$];
	logic [31:0] known_syms [$];

	function automatic chunk_t mk(logic [31:0] cb, int bc, bit l, bit f);
		chunk_t c;
		c.code_bits = cb; c.bit_count = 6'(bc); c.last = l; c.table_full = f;
		return c;
	endfunction

	function automatic void add_row(logic [31:0] sym, bit typed = 0, chunk_t c = '0);
		row_t r;
		r.symbol = sym; r.typed = typed; r.chunk = c;
		dir_rows.push_back(r);
	endfunction

	initial begin
		logic [31:0] sym;
		int r;
		n_used = 1;
		for (int i = 0; i < DEPTH; i++) begin
			sym_tab[i] = '0;
			cnt_tab[i] = '0;
		end
		sym_tab[0] = asfe_pkg::ESCAPE_VALUE;
		cnt_tab[0] = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first symbol on a one-entry table sends only its raw bits
		add_row(32'h8000_0000, 1, mk(32'h8000_0000, 32, 1, 0));
		add_row(32'h8000_0000);
		add_row(asfe_pkg::ESCAPE_VALUE);
		add_row(32'h7fff_fffe);
		add_row(32'h0000_0000);
		add_row(32'hffff_ffff);
		add_row(32'h5555_5555);
		add_row(32'haaaa_aaaa);
		add_row(32'h0000_0000);
		add_row(32'h0000_0000);
		add_row(32'h7fff_fffe);
		add_row(asfe_pkg::ESCAPE_VALUE);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].typed) begin
				send_symbol(dir_rows[i].symbol, 0);
				if (pending_chunks.size() != 1 || pending_chunks[0] !== dir_rows[i].chunk) begin
					$display("%0t directed row %0d: table prediction %p", $time, i,
						dir_rows[i].chunk);
					n_errors++;
				end
			end else begin
				send_symbol(dir_rows[i].symbol, 1);
			end
		end
		s_tvalid <= 1'b0;
		foreach (dir_rows[i]) known_syms.push_back(dir_rows[i].symbol);

		// hold the sender until everything has drained
		wait_drained();

		// random: mostly repeats of known symbols, some fresh ones to fill the table
		for (int n = 0; n < N_RANDOM; n++) begin
			gaps_on = (n / 30) % 3 != 1;
			r = $urandom_range(0, 99);
			if (r < 55 && known_syms.size() > 0)
				sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
			else if (r < 58)
				sym = asfe_pkg::ESCAPE_VALUE;
			else begin
				sym = $urandom;
				if (sym == asfe_pkg::ESCAPE_VALUE) sym = 32'h0;
				known_syms.push_back(sym);
			end
			send_symbol(sym, gaps_on);
		end
		s_tvalid <= 1'b0;

		// finish: drain, then allow the tail latency
		wait_drained();
		repeat (200) @(posedge clk);
		if (n_errors == 0 && pending_chunks.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
